FILE: rtl/dmac_pkg.sv
// shared types and constants of the two-channel dma controller
// no dependencies; imported by dmac_ctrl, dmac_dp and the top level
package dmac_pkg;

   localparam int NUM_CH   = 2;
   localparam int PTR_W    = 20;
   localparam int DATA_W   = 16;
   localparam int HI_W     = 4;
   localparam int TICK_W   = 6;
   localparam int DEBT_W   = 5;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 64;

   // control word bit positions
   localparam int CW_DMEM = 15;
   localparam int CW_DDEC = 14;
   localparam int CW_DINC = 13;
   localparam int CW_SMEM = 12;
   localparam int CW_SDEC = 11;
   localparam int CW_SINC = 10;
   localparam int CW_TC   = 9;
   localparam int CW_INT  = 8;
   localparam int CW_MODE_HI = 7;
   localparam int CW_MODE_LO = 6;
   localparam int CW_IDRQ = 4;
   localparam int CW_CHG  = 2;
   localparam int CW_STRT = 1;
   localparam int CW_WORD = 0;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_DST  = 2'd2;

   localparam logic [DEBT_W-1:0] XFER_COST  = DEBT_W'(8);
   localparam logic [DEBT_W-1:0] DSYNC_COST = DEBT_W'(10);
   localparam logic [DEBT_W-1:0] DEBT_MAX   = DEBT_W'(20);

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_DREQ  = 2'd2,
      ACT_TICK  = 2'd3
   } dmac_action_type;

   typedef enum logic [1:0] {
      KIND_ACK  = 2'd0,
      KIND_READ = 2'd1,
      KIND_XFER = 2'd2
   } dmac_kind_type;

   typedef enum logic [2:0] {
      SEL_SRC_LO  = 3'd0,
      SEL_SRC_HI  = 3'd1,
      SEL_DST_LO  = 3'd2,
      SEL_DST_HI  = 3'd3,
      SEL_COUNT   = 3'd4,
      SEL_CONTROL = 3'd5
   } dmac_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PASS,
      ST_VISIT0,
      ST_VISIT1,
      ST_PASS_END,
      ST_ACK
   } dmac_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch the accepted item
      logic exec;        // perform register access or dreq change, emit its result
      logic pass_start;  // budget covers debt: spend it and begin a pass
      logic pass_hold;   // budget short: carry remaining debt
      logic visit;       // channel visit_ch transfers and emits a command
      logic visit_ch;
      logic emit_ack;    // closing acknowledge of a tick
   } dmac_cmd_type;

   // datapath to controller
   typedef struct packed {
      dmac_action_type action;
      logic            out_free;
      logic [NUM_CH-1:0] ready;
      logic            covers;
      logic            debt_zero;
   } dmac_status_type;

endpackage

FILE: rtl/dmac_ctrl.sv
// sequencer of the dma controller: accepts items and walks tick passes
// depends on dmac_pkg; drives dmac_dp through command and status structs
module dmac_ctrl
   import dmac_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  dmac_status_type status,
   output dmac_cmd_type    cmd
);

   dmac_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.action == ACT_TICK) begin
               state_in = ST_PASS;
            end else if (status.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_PASS: begin
            if (status.covers) begin
               cmd.pass_start = 1'b1;
               state_in       = ST_VISIT0;
            end else begin
               cmd.pass_hold = 1'b1;
               state_in      = ST_ACK;
            end
         end
         ST_VISIT0: begin
            cmd.visit_ch = 1'b0;
            if (!status.ready[0]) begin
               state_in = ST_VISIT1;
            end else if (status.out_free) begin
               cmd.visit = 1'b1;
               state_in  = ST_VISIT1;
            end
         end
         ST_VISIT1: begin
            cmd.visit_ch = 1'b1;
            if (!status.ready[1]) begin
               state_in = ST_PASS_END;
            end else if (status.out_free) begin
               cmd.visit = 1'b1;
               state_in  = ST_PASS_END;
            end
         end
         ST_PASS_END: begin
            // a pass without any transfer ends the tick
            state_in = status.debt_zero ? ST_ACK : ST_PASS;
         end
         ST_ACK: begin
            if (status.out_free) begin
               cmd.emit_ack = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/dmac_dp.sv
// datapath of the dma controller: channel registers, cycle debt, result register
// depends on dmac_pkg; steered by dmac_ctrl
module dmac_dp
   import dmac_pkg::*;
#(
   parameter int MAX_TICK = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dmac_cmd_type          cmd,
   output dmac_status_type       status,
   input  dmac_action_type       req_action,
   input  logic                  req_channel,
   input  logic [2:0]            req_reg_select,
   input  logic [DATA_W-1:0]     req_write_data,
   input  logic                  req_dreq_level,
   input  logic [TICK_W-1:0]     req_tick_cycles,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output dmac_kind_type         rsp_kind,
   output logic [DATA_W-1:0]     rsp_read_data,
   output logic                  rsp_xfer_channel,
   output logic [PTR_W-1:0]      rsp_src_addr,
   output logic [PTR_W-1:0]      rsp_dst_addr,
   output logic                  rsp_src_is_memory,
   output logic                  rsp_dst_is_memory,
   output logic                  rsp_word_transfer,
   output logic                  rsp_irq0_level,
   output logic                  rsp_irq1_level,
   output logic                  rsp_last
);

   function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p,
                                                 input logic inc, input logic dec,
                                                 input logic word);
      logic [PTR_W-1:0] amt;
      amt = word ? PTR_W'(2) : PTR_W'(1);
      if (inc && !dec) begin
         return p + amt;
      end else if (dec && !inc) begin
         return p - amt;
      end
      return p;
   endfunction

   // latched item
   dmac_action_type   act_ff, act_in;
   logic              ch_ff, ch_in;
   logic [2:0]        sel_ff, sel_in;
   logic [DATA_W-1:0] wdata_ff, wdata_in;
   logic              lvl_ff, lvl_in;
   logic [TICK_W-1:0] cnt_ff, cnt_in;

   // channel state
   logic [DATA_W-1:0] ctl_ff [NUM_CH];
   logic [DATA_W-1:0] ctl_in [NUM_CH];
   logic [DATA_W-1:0] count_ff [NUM_CH];
   logic [DATA_W-1:0] count_in [NUM_CH];
   logic [PTR_W-1:0]  src_ff [NUM_CH];
   logic [PTR_W-1:0]  src_in [NUM_CH];
   logic [PTR_W-1:0]  dst_ff [NUM_CH];
   logic [PTR_W-1:0]  dst_in [NUM_CH];
   logic [NUM_CH-1:0] dreq_ff, dreq_in;
   logic [NUM_CH-1:0] irq_ff, irq_in;
   logic [DEBT_W-1:0] debt_ff, debt_in;

   // result register
   logic              rv_ff, rv_in;
   dmac_kind_type     rkind_ff, rkind_in;
   logic [DATA_W-1:0] rdata_ff, rdata_in;
   logic              rch_ff, rch_in;
   logic [PTR_W-1:0]  rsrc_ff, rsrc_in;
   logic [PTR_W-1:0]  rdst_ff, rdst_in;
   logic              rsmem_ff, rsmem_in;
   logic              rdmem_ff, rdmem_in;
   logic              rword_ff, rword_in;
   logic [NUM_CH-1:0] rirq_ff, rirq_in;
   logic              rlast_ff, rlast_in;

   logic              acc_ch;
   logic [DATA_W-1:0] acc_ctl;
   logic [1:0]        acc_mode;
   logic [DATA_W-1:0] count_dec;
   logic              load;
   logic [NUM_CH-1:0] ready;

   assign acc_ch   = cmd.visit ? cmd.visit_ch : ch_ff;
   assign acc_ctl  = ctl_ff[acc_ch];
   assign acc_mode = acc_ctl[CW_MODE_HI:CW_MODE_LO];
   assign count_dec = count_ff[acc_ch] - DATA_W'(1);
   assign load     = cmd.exec | cmd.visit | cmd.emit_ack;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         ready[c] = ctl_ff[c][CW_STRT] &&
                    (ctl_ff[c][CW_MODE_HI:CW_MODE_LO] == MODE_NONE ||
                     (!ctl_ff[c][CW_IDRQ] && dreq_ff[c]));
      end
   end

   assign status.action    = act_ff;
   assign status.out_free  = !rv_ff || rsp_tready;
   assign status.ready     = ready;
   assign status.covers    = cnt_ff >= {1'b0, debt_ff};
   assign status.debt_zero = debt_ff == '0;

   // item latch and tick budget
   always_comb begin
      act_in   = act_ff;
      ch_in    = ch_ff;
      sel_in   = sel_ff;
      wdata_in = wdata_ff;
      lvl_in   = lvl_ff;
      cnt_in   = cnt_ff;
      if (cmd.capture) begin
         act_in   = req_action;
         ch_in    = req_channel;
         sel_in   = req_reg_select;
         wdata_in = req_write_data;
         lvl_in   = req_dreq_level;
         cnt_in   = req_tick_cycles;
         if (32'(req_tick_cycles) > MAX_TICK) begin
            cnt_in = TICK_W'(MAX_TICK);
         end
      end else if (cmd.pass_start) begin
         cnt_in = cnt_ff - TICK_W'(debt_ff);
      end
   end

   // channel state updates
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         ctl_in[c]   = ctl_ff[c];
         count_in[c] = count_ff[c];
         src_in[c]   = src_ff[c];
         dst_in[c]   = dst_ff[c];
      end
      dreq_in = dreq_ff;
      irq_in  = irq_ff;
      debt_in = debt_ff;

      if (cmd.exec && act_ff == ACT_WRITE) begin
         case (sel_ff)
            SEL_SRC_LO: src_in[acc_ch][DATA_W-1:0] = wdata_ff;
            SEL_SRC_HI: src_in[acc_ch][PTR_W-1:DATA_W] = wdata_ff[HI_W-1:0];
            SEL_DST_LO: dst_in[acc_ch][DATA_W-1:0] = wdata_ff;
            SEL_DST_HI: dst_in[acc_ch][PTR_W-1:DATA_W] = wdata_ff[HI_W-1:0];
            SEL_COUNT: begin
               irq_in[acc_ch]   = 1'b0;
               count_in[acc_ch] = wdata_ff;
            end
            SEL_CONTROL: begin
               irq_in[acc_ch] = 1'b0;
               ctl_in[acc_ch] = wdata_ff;
               if (!wdata_ff[CW_CHG]) begin
                  // start bit survives unless the change bit is set
                  ctl_in[acc_ch][CW_STRT] = acc_ctl[CW_STRT];
               end
            end
            default: ;
         endcase
      end

      if (cmd.exec && act_ff == ACT_DREQ) begin
         dreq_in[acc_ch] = lvl_ff;
      end

      if (cmd.pass_start) begin
         debt_in = '0;
      end else if (cmd.pass_hold) begin
         debt_in = debt_ff - cnt_ff[DEBT_W-1:0];
      end

      if (cmd.visit) begin
         src_in[acc_ch]   = step_ptr(src_ff[acc_ch], acc_ctl[CW_SINC], acc_ctl[CW_SDEC],
                                     acc_ctl[CW_WORD]);
         dst_in[acc_ch]   = step_ptr(dst_ff[acc_ch], acc_ctl[CW_DINC], acc_ctl[CW_DDEC],
                                     acc_ctl[CW_WORD]);
         count_in[acc_ch] = count_dec;
         if (count_dec == '0 && acc_ctl[CW_TC]) begin
            ctl_in[acc_ch][CW_STRT] = 1'b0;
            if (acc_ctl[CW_INT]) begin
               irq_in[acc_ch] = 1'b1;
            end
         end
         debt_in = debt_ff + ((acc_mode == MODE_DST) ? DSYNC_COST : XFER_COST);
      end
   end

   // result register
   always_comb begin
      rv_in    = rv_ff && !rsp_tready;
      rkind_in = rkind_ff;
      rdata_in = rdata_ff;
      rch_in   = rch_ff;
      rsrc_in  = rsrc_ff;
      rdst_in  = rdst_ff;
      rsmem_in = rsmem_ff;
      rdmem_in = rdmem_ff;
      rword_in = rword_ff;
      rirq_in  = rirq_ff;
      rlast_in = rlast_ff;
      if (load) begin
         rv_in    = 1'b1;
         rkind_in = KIND_ACK;
         rdata_in = '0;
         rch_in   = 1'b0;
         rsrc_in  = '0;
         rdst_in  = '0;
         rsmem_in = 1'b0;
         rdmem_in = 1'b0;
         rword_in = 1'b0;
         rirq_in  = irq_in;
         rlast_in = !cmd.visit;
         if (cmd.exec && act_ff == ACT_READ) begin
            rkind_in = KIND_READ;
            case (sel_ff)
               SEL_SRC_LO:  rdata_in = src_ff[acc_ch][DATA_W-1:0];
               SEL_SRC_HI:  rdata_in = DATA_W'(src_ff[acc_ch][PTR_W-1:DATA_W]);
               SEL_DST_LO:  rdata_in = dst_ff[acc_ch][DATA_W-1:0];
               SEL_DST_HI:  rdata_in = DATA_W'(dst_ff[acc_ch][PTR_W-1:DATA_W]);
               SEL_COUNT:   rdata_in = count_ff[acc_ch];
               SEL_CONTROL: rdata_in = acc_ctl;
               default:     rdata_in = '0;
            endcase
         end
         if (cmd.visit) begin
            rkind_in = KIND_XFER;
            rch_in   = acc_ch;
            rsrc_in  = src_ff[acc_ch];
            rdst_in  = dst_ff[acc_ch];
            rsmem_in = acc_ctl[CW_SMEM];
            rdmem_in = acc_ctl[CW_DMEM];
            rword_in = acc_ctl[CW_WORD];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) begin
            ctl_ff[c]   <= '0;
            count_ff[c] <= '0;
            src_ff[c]   <= '0;
            dst_ff[c]   <= '0;
         end
         dreq_ff <= '0;
         irq_ff  <= '0;
         debt_ff <= '0;
         rv_ff   <= 1'b0;
      end else begin
         for (int c = 0; c < NUM_CH; c++) begin
            ctl_ff[c]   <= ctl_in[c];
            count_ff[c] <= count_in[c];
            src_ff[c]   <= src_in[c];
            dst_ff[c]   <= dst_in[c];
         end
         dreq_ff <= dreq_in;
         irq_ff  <= irq_in;
         debt_ff <= debt_in;
         rv_ff   <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      ch_ff    <= ch_in;
      sel_ff   <= sel_in;
      wdata_ff <= wdata_in;
      lvl_ff   <= lvl_in;
      cnt_ff   <= cnt_in;
      rkind_ff <= rkind_in;
      rdata_ff <= rdata_in;
      rch_ff   <= rch_in;
      rsrc_ff  <= rsrc_in;
      rdst_ff  <= rdst_in;
      rsmem_ff <= rsmem_in;
      rdmem_ff <= rdmem_in;
      rword_ff <= rword_in;
      rirq_ff  <= rirq_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_tvalid        = rv_ff;
   assign rsp_kind          = rkind_ff;
   assign rsp_read_data     = rdata_ff;
   assign rsp_xfer_channel  = rch_ff;
   assign rsp_src_addr      = rsrc_ff;
   assign rsp_dst_addr      = rdst_ff;
   assign rsp_src_is_memory = rsmem_ff;
   assign rsp_dst_is_memory = rdmem_ff;
   assign rsp_word_transfer = rword_ff;
   assign rsp_irq0_level    = rirq_ff[0];
   assign rsp_irq1_level    = rirq_ff[1];
   assign rsp_last          = rlast_ff;

`ifndef NO_ASSERTIONS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rv_ff || rsp_tready))
      else $error("result register overwritten while still held");
   a_pass_clears_debt: assert property (@(posedge clock) disable iff (reset)
      cmd.pass_start |=> debt_ff == '0)
      else $error("debt not cleared at pass start");
   a_debt_bound: assert property (@(posedge clock) disable iff (reset)
      debt_ff <= DEBT_MAX)
      else $error("cycle debt beyond two transfers");
   a_xfer_not_last: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rkind_ff == KIND_XFER |-> !rlast_ff)
      else $error("transfer command marked last");
`endif

endmodule

FILE: rtl/two_channel_dma_controller_top.sv
// Two-channel dma controller. One item is taken at a time: a register write, a
// register read or a dreq change is executed after acceptance and gives a single
// result, and a time tick runs passes over the channels until the budget falls
// short of the debt or a pass makes no transfer, emitting its transfer commands
// (at most eight) and then one acknowledge; in each pass the sequencer state
// machine visits channel 0 then channel 1.
// Results wait in one output register, so the next item is accepted while the
// last result of the previous one is still held; a stalled result port stalls
// the pass in progress. There is no clearing pass after reset.
// depends on dmac_pkg, dmac_ctrl and dmac_dp
module two_channel_dma_controller_top
   import dmac_pkg::*;
#(
   parameter int MAX_TICK = 63
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // channel[0], reg_select[3:1], write_data[19:4], dreq_level[20],
   // tick_cycles[26:21], zeros above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_data[15:0], xfer_channel[16], src_addr[36:17], dst_addr[56:37],
   // src_is_memory[57], dst_is_memory[58], word_transfer[59], irq0_level[60],
   // irq1_level[61], zeros above
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // kind[1:0]
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   dmac_cmd_type    cmd;
   dmac_status_type status;
   dmac_kind_type   kind;
   logic [DATA_W-1:0] read_data;
   logic              xfer_channel;
   logic [PTR_W-1:0]  src_addr;
   logic [PTR_W-1:0]  dst_addr;
   logic              src_is_memory;
   logic              dst_is_memory;
   logic              word_transfer;
   logic              irq0_level;
   logic              irq1_level;

   dmac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dmac_dp #(
      .MAX_TICK (MAX_TICK)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (dmac_action_type'(req_tuser)),
      .req_channel       (req_tdata[0]),
      .req_reg_select    (req_tdata[3:1]),
      .req_write_data    (req_tdata[19:4]),
      .req_dreq_level    (req_tdata[20]),
      .req_tick_cycles   (req_tdata[26:21]),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_kind          (kind),
      .rsp_read_data     (read_data),
      .rsp_xfer_channel  (xfer_channel),
      .rsp_src_addr      (src_addr),
      .rsp_dst_addr      (dst_addr),
      .rsp_src_is_memory (src_is_memory),
      .rsp_dst_is_memory (dst_is_memory),
      .rsp_word_transfer (word_transfer),
      .rsp_irq0_level    (irq0_level),
      .rsp_irq1_level    (irq1_level),
      .rsp_last          (rsp_tlast)
   );

   assign rsp_tuser = kind;
   assign rsp_tdata = {2'b00, irq1_level, irq0_level, word_transfer, dst_is_memory,
                       src_is_memory, dst_addr, src_addr, xfer_channel, read_data};

endmodule
